@@ hw/rtl/ccm_pkg.sv @@
`default_nettype none
package ccm_pkg;

    // Geometry and fixed-point sizing
    localparam int COORD_BITS      = 12;
    localparam int PERIM_FRAC_BITS = 8;
    localparam int ACC_W           = 40;
    localparam int MIN_AREA_W      = 24;
    localparam int CIRC_W          = 16;

    localparam logic [MIN_AREA_W-1:0] MIN_AREA_RST = MIN_AREA_W'(20);
    // 2*pi in Q30
    localparam logic [ACC_W-1:0]      TWO_PI_Q30   = ACC_W'(64'd6746518852);

    // Edge length: squared distance and square root sizing
    localparam int XP_W       = 2 * COORD_BITS;
    localparam int DELTA_W    = XP_W + 1;
    localparam int D2_W       = XP_W + 1;
    localparam int SQRT_STEPS = (D2_W + 1) / 2 + PERIM_FRAC_BITS;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int RAD_W      = 2 * SQRT_STEPS;
    localparam int REM_W      = SQRT_STEPS + 2;

    // Circularity: split multiplier and restoring divider
    localparam int HALF_W  = ACC_W / 2;
    localparam int PROD_W  = 2 * ACC_W;
    localparam int DSH_W   = PROD_W + CIRC_W;
    localparam int CNT_MAX = (SQRT_STEPS > CIRC_W + 1) ? SQRT_STEPS : CIRC_W + 1;
    localparam int CNT_W   = $clog2(CNT_MAX);
    localparam int BIT_W   = $clog2(CIRC_W);

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic                  end_of_contour;
        logic                  end_of_list;
    } in_word_t;

    typedef struct packed {
        logic [CIRC_W-1:0] best_circularity;
        logic              any_found;
    } out_word_t;

    // One classified point for the back end
    typedef struct packed {
        logic [COORD_BITS-1:0] cur_x;
        logic [COORD_BITS-1:0] cur_y;
        logic [COORD_BITS-1:0] prev_x;
        logic [COORD_BITS-1:0] prev_y;
        logic [COORD_BITS-1:0] first_x;
        logic [COORD_BITS-1:0] first_y;
        logic                  has_edge;
        logic                  has_close;
        logic                  is_end;
        logic                  is_eol;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/ccm_front.sv @@
`default_nettype none
module ccm_front (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic push,
    input  ccm_pkg::in_word_t  in_data,
    input  ccm_pkg::q_status_t q_status,
    output logic               q_wr,
    output ccm_pkg::q_entry_t  q_wdata
);
    import ccm_pkg::*;

    logic [COORD_BITS-1:0] first_x_reg, first_x_next;
    logic [COORD_BITS-1:0] first_y_reg, first_y_next;
    logic [COORD_BITS-1:0] prev_x_reg, prev_x_next;
    logic [COORD_BITS-1:0] prev_y_reg, prev_y_next;
    logic [1:0]            seen_reg, seen_next;
    logic                  end_c;

    assign q_wr  = push && !q_status.full;
    assign end_c = in_data.end_of_contour || in_data.end_of_list;

    // Classify the point: open edge, closing edge, contour and list ends
    always_comb
    begin
        q_wdata.cur_x     = in_data.point_x;
        q_wdata.cur_y     = in_data.point_y;
        q_wdata.prev_x    = prev_x_reg;
        q_wdata.prev_y    = prev_y_reg;
        q_wdata.first_x   = (seen_reg == 2'd0) ? in_data.point_x : first_x_reg;
        q_wdata.first_y   = (seen_reg == 2'd0) ? in_data.point_y : first_y_reg;
        q_wdata.has_edge  = (seen_reg != 2'd0);
        q_wdata.has_close = end_c && (seen_reg >= 2'd2);
        q_wdata.is_end    = end_c;
        q_wdata.is_eol    = in_data.end_of_list;
    end

    // Contour tracking state
    always_comb
    begin
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        seen_next    = seen_reg;
        if (q_wr)
        begin
            if (end_c)
            begin
                first_x_next = '0;
                first_y_next = '0;
                prev_x_next  = '0;
                prev_y_next  = '0;
                seen_next    = 2'd0;
            end
            else
            begin
                first_x_next = q_wdata.first_x;
                first_y_next = q_wdata.first_y;
                prev_x_next  = in_data.point_x;
                prev_y_next  = in_data.point_y;
                seen_next    = (seen_reg == 2'd3) ? 2'd3 : seen_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            seen_reg    <= 2'd0;
        end
        else
        begin
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
            prev_x_reg  <= prev_x_next;
            prev_y_reg  <= prev_y_next;
            seen_reg    <= seen_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/ccm_queue.sv @@
`default_nettype none
module ccm_queue (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic wr,
    input  ccm_pkg::q_entry_t  wdata,
    input  wire                logic rd,
    output ccm_pkg::q_entry_t  rdata,
    output ccm_pkg::q_status_t status
);
    import ccm_pkg::*;

    q_entry_t          mem_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign status.full  = (cnt_reg == QCNT_W'(Q_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign rdata        = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/ccm_back.sv @@
`default_nettype none
module ccm_back (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic cfg_wr_en,
    input  wire                logic [ccm_pkg::MIN_AREA_W-1:0] cfg_wr_data,
    input  ccm_pkg::q_status_t q_status,
    input  ccm_pkg::q_entry_t  q_rdata,
    output logic               q_rd,
    input  wire                logic pop,
    output logic               empty,
    output ccm_pkg::out_word_t out_data
);
    import ccm_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_NEXT = 9'b000000010,
        S_PREP = 9'b000000100,
        S_SQRT = 9'b000001000,
        S_ACC  = 9'b000010000,
        S_CHK  = 9'b000100000,
        S_MUL  = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_UPD  = 9'b100000000
    } state_t;

    state_t                state_reg, state_next;
    q_entry_t              ent_reg, ent_next;
    logic                  pend_edge_reg, pend_edge_next;
    logic                  pend_close_reg, pend_close_next;
    logic                  pend_end_reg, pend_end_next;
    logic                  pend_eol_reg, pend_eol_next;
    logic                  eval_reg, eval_next;
    logic [COORD_BITS-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [COORD_BITS-1:0] bx_reg, bx_next, by_reg, by_next;
    logic [DELTA_W-1:0]    delta_reg, delta_next;
    logic [RAD_W-1:0]      rad_reg, rad_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ACC_W-1:0]      twice_reg, twice_next;
    logic [ACC_W-1:0]      perim_reg, perim_next;
    logic [ACC_W-1:0]      mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic                  second_reg, second_next;
    logic [PROD_W-1:0]     num_reg, num_next;
    logic [DSH_W-1:0]      dsh_reg, dsh_next;
    logic [CIRC_W-1:0]     circ_reg, circ_next;
    logic [CIRC_W-1:0]     best_reg, best_next;
    logic                  have_reg, have_next;
    logic                  out_valid_reg, out_valid_next;
    out_word_t             out_reg, out_next;
    logic [MIN_AREA_W-1:0] min_area_reg;

    // Datapath helpers
    logic [XP_W-1:0]        p_c, q_c;
    logic [COORD_BITS-1:0]  dx_c, dy_c;
    logic [D2_W-1:0]        d2_c;
    logic [REM_W-1:0]       rem_sh_c, trial_c;
    logic [ACC_W-1:0]       abs_twice_c;
    logic [ACC_W:0]         perim_sum_c;
    logic [HALF_W-1:0]      ma_c, mb_c;
    logic [2*HALF_W-1:0]    pp_c;
    logic [PROD_W-1:0]      pp_sh_c, prod_acc_c;
    logic                   div_ge_c;
    logic                   emit_c;

    assign empty    = !out_valid_reg;
    assign out_data = out_reg;

    // Edge products, squared distance, one square-root step
    always_comb
    begin
        p_c      = XP_W'(ax_reg) * XP_W'(by_reg);
        q_c      = XP_W'(bx_reg) * XP_W'(ay_reg);
        dx_c     = (ax_reg > bx_reg) ? ax_reg - bx_reg : bx_reg - ax_reg;
        dy_c     = (ay_reg > by_reg) ? ay_reg - by_reg : by_reg - ay_reg;
        d2_c     = D2_W'(XP_W'(dx_c) * XP_W'(dx_c)) + D2_W'(XP_W'(dy_c) * XP_W'(dy_c));
        rem_sh_c = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial_c  = {root_reg, 2'b01};
    end

    // Accumulator helpers, split multiplier, divider compare
    always_comb
    begin
        abs_twice_c = twice_reg[ACC_W-1] ? (~twice_reg + 1'b1) : twice_reg;
        perim_sum_c = {1'b0, perim_reg} + (ACC_W + 1)'(root_reg);
        ma_c        = cnt_reg[1] ? mul_a_reg[ACC_W-1:HALF_W] : mul_a_reg[HALF_W-1:0];
        mb_c        = cnt_reg[0] ? mul_b_reg[ACC_W-1:HALF_W] : mul_b_reg[HALF_W-1:0];
        pp_c        = ma_c * mb_c;
        unique case ({cnt_reg[1], cnt_reg[0]})
            2'b00:   pp_sh_c = PROD_W'(pp_c);
            2'b11:   pp_sh_c = PROD_W'(pp_c) << ACC_W;
            default: pp_sh_c = PROD_W'(pp_c) << HALF_W;
        endcase
        prod_acc_c  = prod_reg + pp_sh_c;
        div_ge_c    = {{CIRC_W{1'b0}}, num_reg} >= dsh_reg;
        emit_c      = (state_reg == S_NEXT) && !pend_edge_reg && !pend_close_reg
                      && !pend_end_reg && pend_eol_reg && (!out_valid_reg || pop);
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        ent_next        = ent_reg;
        pend_edge_next  = pend_edge_reg;
        pend_close_next = pend_close_reg;
        pend_end_next   = pend_end_reg;
        pend_eol_next   = pend_eol_reg;
        eval_next       = eval_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        bx_next         = bx_reg;
        by_next         = by_reg;
        delta_next      = delta_reg;
        rad_next        = rad_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        cnt_next        = cnt_reg;
        twice_next      = twice_reg;
        perim_next      = perim_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        prod_next       = prod_reg;
        second_next     = second_reg;
        num_next        = num_reg;
        dsh_next        = dsh_reg;
        circ_next       = circ_reg;
        best_next       = best_reg;
        have_next       = have_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !pop;
        q_rd            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_rd            = 1'b1;
                    ent_next        = q_rdata;
                    pend_edge_next  = q_rdata.has_edge;
                    pend_close_next = q_rdata.has_close;
                    pend_end_next   = q_rdata.is_end;
                    pend_eol_next   = q_rdata.is_eol;
                    state_next      = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (pend_edge_reg)
                begin
                    ax_next        = ent_reg.prev_x;
                    ay_next        = ent_reg.prev_y;
                    bx_next        = ent_reg.cur_x;
                    by_next        = ent_reg.cur_y;
                    pend_edge_next = 1'b0;
                    state_next     = S_PREP;
                end
                else if (pend_close_reg)
                begin
                    ax_next         = ent_reg.cur_x;
                    ay_next         = ent_reg.cur_y;
                    bx_next         = ent_reg.first_x;
                    by_next         = ent_reg.first_y;
                    pend_close_next = 1'b0;
                    eval_next       = 1'b1;
                    state_next      = S_PREP;
                end
                else if (pend_end_reg)
                begin
                    if (eval_reg)
                    begin
                        state_next = S_CHK;
                    end
                    else
                    begin
                        twice_next    = '0;
                        perim_next    = '0;
                        pend_end_next = 1'b0;
                    end
                end
                else if (pend_eol_reg)
                begin
                    if (emit_c)
                    begin
                        out_next.best_circularity = have_reg ? best_reg : '0;
                        out_next.any_found        = have_reg;
                        out_valid_next            = 1'b1;
                        best_next                 = '0;
                        have_next                 = 1'b0;
                        pend_eol_next             = 1'b0;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PREP:
            begin
                delta_next = {1'b0, p_c} - {1'b0, q_c};
                rad_next   = RAD_W'(d2_c) << (2 * PERIM_FRAC_BITS);
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = CNT_W'(SQRT_STEPS - 1);
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                rad_next = rad_reg << 2;
                if (rem_sh_c >= trial_c)
                begin
                    rem_next  = rem_sh_c - trial_c;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh_c;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_ACC:
            begin
                twice_next = twice_reg + {{(ACC_W - DELTA_W){delta_reg[DELTA_W-1]}}, delta_reg};
                perim_next = perim_sum_c[ACC_W] ? '1 : perim_sum_c[ACC_W-1:0];
                state_next = S_NEXT;
            end
            S_CHK:
            begin
                if ((abs_twice_c >= ACC_W'({min_area_reg, 1'b0})) && (perim_reg != '0))
                begin
                    mul_a_next  = abs_twice_c;
                    mul_b_next  = TWO_PI_Q30;
                    prod_next   = '0;
                    cnt_next    = '0;
                    second_next = 1'b0;
                    state_next  = S_MUL;
                end
                else
                begin
                    eval_next  = 1'b0;
                    state_next = S_NEXT;
                end
            end
            S_MUL:
            begin
                prod_next = prod_acc_c;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == 2'b11)
                begin
                    cnt_next = '0;
                    if (!second_reg)
                    begin
                        num_next    = prod_acc_c;
                        mul_a_next  = perim_reg;
                        mul_b_next  = perim_reg;
                        prod_next   = '0;
                        second_next = 1'b1;
                    end
                    else
                    begin
                        dsh_next   = {prod_acc_c, {CIRC_W{1'b0}}};
                        cnt_next   = CNT_W'(CIRC_W);
                        circ_next  = '0;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(CIRC_W))
                begin
                    // quotient would not fit: saturate
                    if (div_ge_c)
                    begin
                        circ_next  = '1;
                        state_next = S_UPD;
                    end
                end
                else
                begin
                    if (div_ge_c)
                    begin
                        num_next  = num_reg - dsh_reg[PROD_W-1:0];
                        circ_next = circ_reg | (CIRC_W'(1) << cnt_reg[BIT_W-1:0]);
                    end
                    if (cnt_reg == '0)
                    begin
                        state_next = S_UPD;
                    end
                end
            end
            S_UPD:
            begin
                if (!have_reg || (circ_reg > best_reg))
                begin
                    best_next = circ_reg;
                    have_next = 1'b1;
                end
                eval_next  = 1'b0;
                state_next = S_NEXT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ent_reg    <= ent_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        delta_reg  <= delta_next;
        rad_reg    <= rad_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        mul_a_reg  <= mul_a_next;
        mul_b_reg  <= mul_b_next;
        prod_reg   <= prod_next;
        num_reg    <= num_next;
        dsh_reg    <= dsh_next;
        circ_reg   <= circ_next;
        out_reg    <= out_next;
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_edge_reg  <= 1'b0;
            pend_close_reg <= 1'b0;
            pend_end_reg   <= 1'b0;
            pend_eol_reg   <= 1'b0;
            eval_reg       <= 1'b0;
            cnt_reg        <= '0;
            second_reg     <= 1'b0;
            twice_reg      <= '0;
            perim_reg      <= '0;
            best_reg       <= '0;
            have_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            min_area_reg   <= MIN_AREA_RST;
        end
        else
        begin
            state_reg      <= state_next;
            pend_edge_reg  <= pend_edge_next;
            pend_close_reg <= pend_close_next;
            pend_end_reg   <= pend_end_next;
            pend_eol_reg   <= pend_eol_next;
            eval_reg       <= eval_next;
            cnt_reg        <= cnt_next;
            second_reg     <= second_next;
            twice_reg      <= twice_next;
            perim_reg      <= perim_next;
            best_reg       <= best_next;
            have_reg       <= have_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                min_area_reg <= cfg_wr_data;
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/contour_circularity_max_top.sv @@
`default_nettype none
// Best circularity over a list of contours. Points enter one word at a time;
// the front end tags each with its edges and contour/list ends and places it in a
// two-word queue, so push is refused only while that queue is full. The back end
// handles one queued word at a time on a shared edge unit: each edge runs through
// the 21-step bit-serial square root of the edge length. A contour end that
// qualifies adds the split 40x40 multiplier and the 17-step restoring divider.
// One result word is written per end of list into an output register that pop
// drains; min_area may be written only while the block is idle.
module contour_circularity_max_top (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic push,
    output logic               full,
    input  ccm_pkg::in_word_t  in_data,
    output logic               empty,
    input  wire                logic pop,
    output ccm_pkg::out_word_t out_data,
    input  wire                logic cfg_wr_en,
    input  wire                logic [ccm_pkg::MIN_AREA_W-1:0] cfg_wr_data
);
    import ccm_pkg::*;

    q_status_t q_status;
    q_entry_t  q_wdata;
    q_entry_t  q_rdata;
    logic      q_wr;
    logic      q_rd;

    assign full = q_status.full;

    ccm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_data  (in_data),
        .q_status (q_status),
        .q_wr     (q_wr),
        .q_wdata  (q_wdata)
    );

    ccm_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wdata  (q_wdata),
        .rd     (q_rd),
        .rdata  (q_rdata),
        .status (q_status)
    );

    ccm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_status    (q_status),
        .q_rdata     (q_rdata),
        .q_rd        (q_rd),
        .pop         (pop),
        .empty       (empty),
        .out_data    (out_data)
    );

    // Queue cannot be both full and empty
    a_q_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");

    // A word pushed into an empty queue is still there next cycle
    a_q_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && q_status.empty) |=> !q_status.empty)
        else $error("pushed word lost");

    // No qualifying contour means a zero circularity
    a_no_target: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_data.any_found) |-> (out_data.best_circularity == '0))
        else $error("nonzero circularity without a target");

    // Back end never reads an empty queue
    a_q_rd: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> !q_status.empty)
        else $error("read from empty queue");

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import ccm_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_word_t  in_data;
    logic      empty;
    logic      pop;
    out_word_t out_data;
    logic      cfg_wr_en;
    logic [MIN_AREA_W-1:0] cfg_wr_data;

    contour_circularity_max_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_data     (in_data),
        .empty       (empty),
        .pop         (pop),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Shadow of the block's state
    logic [MIN_AREA_W-1:0] area_floor;
    logic [COORD_BITS-1:0] start_x, start_y, last_x, last_y;
    logic [1:0]            pts_in_contour;
    logic [ACC_W-1:0]      area2_acc;
    logic [ACC_W-1:0]      perim_acc;
    logic [CIRC_W-1:0]     best_circ;
    logic                  best_valid;

    out_word_t expected_words[$];
    int  errors;
    int  words_sent;
    int  words_checked;
    int  found_count;
    int  contours_sent;
    bit  no_idle;
    bit  hold_pop;

    // Clock
    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    // floor(sqrt(d2) * 2^8)
    function automatic logic [ACC_W-1:0] edge_length(logic [COORD_BITS-1:0] ax,
                                                     logic [COORD_BITS-1:0] ay,
                                                     logic [COORD_BITS-1:0] bx,
                                                     logic [COORD_BITS-1:0] by);
        longint dx, dy, rad, root, trial;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        rad = (dx * dx + dy * dy) << (2 * PERIM_FRAC_BITS);
        root = 0;
        for (int b = 25; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= rad)
                root = trial;
        end
        return root[ACC_W-1:0];
    endfunction

    function automatic void accumulate_edge(logic [COORD_BITS-1:0] ax,
                                            logic [COORD_BITS-1:0] ay,
                                            logic [COORD_BITS-1:0] bx,
                                            logic [COORD_BITS-1:0] by);
        logic [ACC_W:0] psum;
        area2_acc = area2_acc + ACC_W'(ax) * ACC_W'(by) - ACC_W'(bx) * ACC_W'(ay);
        psum = {1'b0, perim_acc} + {1'b0, edge_length(ax, ay, bx, by)};
        perim_acc = psum[ACC_W] ? '1 : psum[ACC_W-1:0];
    endfunction

    function automatic void finish_contour();
        logic [ACC_W-1:0] mag;
        logic [127:0]     num, den;
        logic [CIRC_W-1:0] circ;
        if (pts_in_contour == 2'd3)
        begin
            accumulate_edge(last_x, last_y, start_x, start_y);
            mag = area2_acc[ACC_W-1] ? -area2_acc : area2_acc;
            if (mag >= 2 * 64'(area_floor) && perim_acc != 0)
            begin
                num = 128'(mag) * 128'(TWO_PI_Q30);
                den = 128'(perim_acc) * 128'(perim_acc);
                if (num >= (den << 16))
                    circ = '1;
                else
                    circ = CIRC_W'(num / den);
                if (!best_valid || circ > best_circ)
                begin
                    best_circ = circ;
                    best_valid = 1'b1;
                end
            end
        end
        start_x = 0; start_y = 0; last_x = 0; last_y = 0;
        pts_in_contour = 0;
        area2_acc = 0;
        perim_acc = 0;
    endfunction

    // Advance the shadow state by one accepted point
    function automatic void predict_point(in_word_t w);
        out_word_t r;
        if (pts_in_contour == 0)
        begin
            start_x = w.point_x;
            start_y = w.point_y;
        end
        else
            accumulate_edge(last_x, last_y, w.point_x, w.point_y);
        last_x = w.point_x;
        last_y = w.point_y;
        if (pts_in_contour != 2'd3)
            pts_in_contour++;
        if (w.end_of_contour || w.end_of_list)
        begin
            finish_contour();
            contours_sent++;
        end
        if (w.end_of_list)
        begin
            r.best_circularity = best_valid ? best_circ : '0;
            r.any_found = best_valid;
            expected_words.push_back(r);
            best_circ = 0;
            best_valid = 0;
        end
    endfunction

    // Offer one word, wait for it to be taken, then maybe idle
    task automatic send_point(int x, int y, bit eoc, bit eol);
        in_word_t w;
        int gap;
        w.point_x = COORD_BITS'(x);
        w.point_y = COORD_BITS'(y);
        w.end_of_contour = eoc;
        w.end_of_list = eol;
        in_data <= w;
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
        predict_point(w);
        words_sent++;
        if (!no_idle && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(1, 11);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic stop_push();
        push <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        stop_push();
        wait (expected_words.size() == 0);
        repeat (150) @(posedge clk);
    endtask

    task automatic set_min_area(int unsigned v);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= MIN_AREA_W'(v);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        area_floor = MIN_AREA_W'(v);
    endtask

    // Result check with random pop stalls, long hold-offs and a constant-pop mode
    initial
    begin
        int stall;
        out_word_t e;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word: best_circularity %0d any_found %0d",
                           out_data.best_circularity, out_data.any_found);
                    errors++;
                end
                else
                begin
                    e = expected_words.pop_front();
                    words_checked++;
                    if (e.any_found)
                        found_count++;
                    if (out_data.best_circularity !== e.best_circularity)
                    begin
                        $error("best_circularity: expected %0d, actual %0d",
                               e.best_circularity, out_data.best_circularity);
                        errors++;
                    end
                    if (out_data.any_found !== e.any_found)
                    begin
                        $error("any_found: expected %0d, actual %0d",
                               e.any_found, out_data.any_found);
                        errors++;
                    end
                end
            end
            if (hold_pop)
                pop <= 1'b0;
            else if (no_idle)
                pop <= 1'b1;
            else if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else if ($urandom_range(3) == 0)
            begin
                stall = $urandom_range(0, 10);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Long receiver hold-off
    initial
    begin
        forever
        begin
            wait (hold_pop);
            repeat (600) @(posedge clk);
            hold_pop = 0;
        end
    end

    // One polygon around a center, points in angular order
    task automatic send_polygon(int n, bit last_in_list, bit close_by_eoc);
        real cx, cy, rad, ang, step;
        int x, y;
        cx = $urandom_range(0, 4095);
        cy = $urandom_range(0, 4095);
        rad = ($urandom_range(3) == 0) ? $urandom_range(1, 2000) : $urandom_range(2, 60);
        ang = $urandom_range(0, 359) * 3.14159265 / 180.0;
        step = 2.0 * 3.14159265 / n;
        for (int i = 0; i < n; i++)
        begin
            x = int'(cx + rad * $cos(ang) + $urandom_range(0, 2)) - 1;
            y = int'(cy + rad * $sin(ang) + $urandom_range(0, 2)) - 1;
            if (x < 0) x = 0;
            if (x > 4095) x = 4095;
            if (y < 0) y = 0;
            if (y > 4095) y = 4095;
            ang += step * (0.5 + $urandom_range(0, 100) / 100.0);
            if (i == n - 1)
                send_point(x, y, close_by_eoc || !last_in_list, last_in_list);
            else
                send_point(x, y, 1'b0, 1'b0);
        end
    endtask

    task automatic send_random_list();
        int nc, n;
        nc = $urandom_range(1, 5);
        for (int c = 0; c < nc; c++)
        begin
            case ($urandom_range(9))
                0: n = $urandom_range(1, 2);
                1: n = $urandom_range(13, 40);
                default: n = $urandom_range(3, 12);
            endcase
            if ($urandom_range(7) == 0)
            begin
                // raw noise points
                for (int i = 0; i < n; i++)
                    send_point($urandom_range(0, 4095), $urandom_range(0, 4095),
                               i == n - 1 && c != nc - 1, i == n - 1 && c == nc - 1);
            end
            else
                send_polygon(n, c == nc - 1, $urandom_range(1));
        end
    endtask

    task automatic test_directed();
        // empty list: lone point ending the list
        send_point(100, 100, 1'b0, 1'b1);
        // two-point contour then list end
        send_point(0, 0, 1'b0, 1'b0);
        send_point(4095, 4095, 1'b1, 1'b1);
        // full-frame square
        send_point(0, 0, 1'b0, 1'b0);
        send_point(4095, 0, 1'b0, 1'b0);
        send_point(4095, 4095, 1'b0, 1'b0);
        send_point(0, 4095, 1'b1, 1'b0);
        // tie: same square again, then a tiny triangle below min_area
        send_point(0, 0, 1'b0, 1'b0);
        send_point(4095, 0, 1'b0, 1'b0);
        send_point(4095, 4095, 1'b0, 1'b0);
        send_point(0, 4095, 1'b1, 1'b0);
        send_point(10, 10, 1'b0, 1'b0);
        send_point(12, 10, 1'b0, 1'b0);
        send_point(10, 12, 1'b0, 1'b1);
        // repeated point: zero perimeter
        send_point(2048, 2048, 1'b0, 1'b0);
        send_point(2048, 2048, 1'b0, 1'b0);
        send_point(2048, 2048, 1'b0, 1'b1);
        // clockwise triangle, negative area sign
        send_point(100, 100, 1'b0, 1'b0);
        send_point(100, 200, 1'b0, 1'b0);
        send_point(200, 100, 1'b1, 1'b1);
        // collinear points: zero area, nonzero perimeter
        send_point(5, 5, 1'b0, 1'b0);
        send_point(6, 6, 1'b0, 1'b0);
        send_point(4000, 4000, 1'b0, 1'b1);
    endtask

    task automatic test_config_sweep();
        int unsigned settings[5] = '{0, 1, 16777215, 500, 20};
        foreach (settings[i])
        begin
            set_min_area(settings[i]);
            for (int k = 0; k < 4; k++)
                send_random_list();
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_pop = 1;
        for (int k = 0; k < 6; k++)
            send_random_list();
    endtask

    task automatic test_random();
        set_min_area($urandom_range(0, 3000));
        while (words_sent < 1100)
            send_random_list();
    endtask

    task automatic test_no_idle();
        wait_idle();
        no_idle = 1;
        for (int k = 0; k < 15; k++)
            send_random_list();
    endtask

    // Main sequence
    initial
    begin
        rst_n = 0;
        push = 0;
        pop = 0;
        in_data = '0;
        cfg_wr_en = 0;
        cfg_wr_data = '0;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        found_count = 0;
        contours_sent = 0;
        no_idle = 0;
        hold_pop = 0;
        area_floor = MIN_AREA_RST;
        start_x = 0; start_y = 0; last_x = 0; last_y = 0;
        pts_in_contour = 0;
        area2_acc = 0;
        perim_acc = 0;
        best_circ = 0;
        best_valid = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random();
        test_no_idle();

        stop_push();
        wait (expected_words.size() == 0);
        repeat (200) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            $error("%0d result words never arrived", expected_words.size());
            errors++;
        end
        $display("Run: %0d points in %0d contours, %0d lists checked (%0d with a target).",
                 words_sent, contours_sent, words_checked, found_count);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ccm_pkg.sv
hw/rtl/ccm_front.sv
hw/rtl/ccm_queue.sv
hw/rtl/ccm_back.sv
hw/rtl/contour_circularity_max_top.sv
bench/tb_top.sv
